[hdl/p7pu_pkg.sv]
// ---------------------------------------------------------------------------
// p7pu_pkg
// shared constants and controller/datapath interface types for the
// pkcs#7 pad/unpad stream unit
// ---------------------------------------------------------------------------
package p7pu_pkg;

  localparam int BLOCK_BYTES_DEF = 16;

  // where the output register takes its byte from
  typedef enum logic [1:0] {
    SRC_IN,
    SRC_PAD,
    SRC_RAM,
    SRC_STATUS
  } out_src_e;

  typedef struct packed {
    logic     cfg_we;
    logic     take;
    logic     emit;
    out_src_e src;
    logic     emit_last;
    logic     emit_err;
    logic     rd_en;
    logic     rd_head;
    logic     chk_start;
    logic     emit_start;
    logic     ptr_step;
    logic     pad_step;
    logic     clear_msg;
  } dp_cmd_t;

  typedef struct packed {
    logic unpad_mode;
    logic full;
    logic slot_free;
    logic last;
    logic pad_ok;
    logic byte_match;
    logic cnt_one;
    logic keep_zero;
  } dp_sts_t;

endpackage

[hdl/p7pu_ram.sv]
// ---------------------------------------------------------------------------
// p7pu_ram
// generic single write port ram with one registered read port
// ---------------------------------------------------------------------------
module p7pu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first: a read and write to the same address return the old entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/p7pu_datapath.sv]
// ---------------------------------------------------------------------------
// p7pu_datapath
// hold window, block phase, pad/read counters and the output register
// ---------------------------------------------------------------------------
module p7pu_datapath #(
  parameter int BLOCK_BYTES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  p7pu_pkg::dp_cmd_t cmd_i,
  output p7pu_pkg::dp_sts_t sts_o,
  input  logic             cfg_data_i,
  input  logic [7:0]       data_byte_i,
  input  logic             is_last_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             out_last_o,
  output logic             pad_error_o
);
  import p7pu_pkg::*;

  localparam int CW = $clog2(BLOCK_BYTES + 1);
  localparam int AW = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;
  localparam int SW = CW + 1;
  localparam logic [CW-1:0] BLK      = CW'(BLOCK_BYTES);
  localparam logic [AW-1:0] LAST_IDX = AW'(BLOCK_BYTES - 1);

  // index a from head, wrapped into the window
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(BLOCK_BYTES)) begin
      sum = sum - SW'(BLOCK_BYTES);
    end
    return sum[AW-1:0];
  endfunction

  logic          mode_q, mode_d;
  logic [CW-1:0] phase_q, phase_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] ptr_q, ptr_d;
  logic [7:0]    pad_q, pad_d;
  logic          last_q, last_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          byte_valid_q, byte_valid_d;
  logic          out_last_q, out_last_d;
  logic          pad_error_q, pad_error_d;

  logic [CW-1:0] phase_next;
  logic [CW-1:0] pad_cnt;
  logic [CW-1:0] pad_len;
  logic [CW-1:0] keep_len;
  logic [AW-1:0] ptr_inc;
  logic [AW-1:0] head_inc;
  logic          full;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign phase_next = (phase_q == BLK - CW'(1)) ? '0 : phase_q + CW'(1);
  assign pad_cnt    = BLK - phase_next;
  assign pad_len    = pad_q[CW-1:0];
  assign keep_len   = fill_q - pad_len;
  assign ptr_inc    = (ptr_q == LAST_IDX) ? '0 : ptr_q + AW'(1);
  assign head_inc   = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
  assign full       = (fill_q == BLK);

  // when full the newest byte overwrites the oldest slot
  assign ram_we    = cmd_i.take && mode_q;
  assign ram_waddr = full ? head_q : wrap_add(head_q, fill_q);
  assign ram_raddr = cmd_i.rd_head ? head_q : ptr_q;

  p7pu_ram #(
    .WIDTH (8),
    .DEPTH (BLOCK_BYTES)
  ) u_hold_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_byte_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    head_d  = head_q;
    fill_d  = fill_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    pad_d   = pad_q;
    last_d  = last_q;

    if (cmd_i.take) begin
      last_d = is_last_i;
      if (mode_q) begin
        pad_d = data_byte_i;
        if (full) begin
          head_d = head_inc;
        end else begin
          fill_d = fill_q + CW'(1);
        end
      end else begin
        phase_d = is_last_i ? '0 : phase_next;
        if (is_last_i) begin
          pad_d = 8'(pad_cnt);
          cnt_d = pad_cnt;
        end
      end
    end
    if (cmd_i.pad_step) begin
      cnt_d = cnt_q - CW'(1);
    end
    if (cmd_i.chk_start) begin
      ptr_d = wrap_add(head_q, keep_len);
      cnt_d = pad_len;
    end
    if (cmd_i.emit_start) begin
      ptr_d = head_q;
      cnt_d = keep_len;
    end
    if (cmd_i.ptr_step) begin
      ptr_d = ptr_inc;
      cnt_d = cnt_q - CW'(1);
    end
    if (cmd_i.clear_msg) begin
      fill_d = '0;
      head_d = '0;
    end
    if (cmd_i.cfg_we) begin
      mode_d  = cfg_data_i;
      fill_d  = '0;
      head_d  = '0;
      phase_d = '0;
    end
  end

  // output register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    byte_valid_d = byte_valid_q;
    out_last_d   = out_last_q;
    pad_error_d  = pad_error_q;
    if (cmd_i.emit) begin
      out_valid_d  = 1'b1;
      out_last_d   = cmd_i.emit_last;
      pad_error_d  = cmd_i.emit_err;
      byte_valid_d = 1'b1;
      unique case (cmd_i.src)
        SRC_IN:     out_byte_d = data_byte_i;
        SRC_PAD:    out_byte_d = pad_q;
        SRC_RAM:    out_byte_d = ram_rdata;
        SRC_STATUS: begin
          out_byte_d   = '0;
          byte_valid_d = 1'b0;
        end
        default:    out_byte_d = '0;
      endcase
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      phase_q     <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      phase_q     <= phase_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q        <= cnt_d;
    ptr_q        <= ptr_d;
    pad_q        <= pad_d;
    last_q       <= last_d;
    out_byte_q   <= out_byte_d;
    byte_valid_q <= byte_valid_d;
    out_last_q   <= out_last_d;
    pad_error_q  <= pad_error_d;
  end

  always_comb begin
    sts_o.unpad_mode = mode_q;
    sts_o.full       = full;
    sts_o.slot_free  = !out_valid_q || !out_stall_i;
    sts_o.last       = last_q;
    sts_o.pad_ok     = (pad_q != 8'd0) && (9'(pad_q) <= 9'(BLOCK_BYTES))
                       && (9'(pad_q) <= 9'(fill_q));
    sts_o.byte_match = (ram_rdata == pad_q);
    sts_o.cnt_one    = (cnt_q == CW'(1));
    sts_o.keep_zero  = (fill_q == pad_len);
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign out_last_o   = out_last_q;
  assign pad_error_o  = pad_error_q;

endmodule

[hdl/p7pu_ctrl.sv]
// ---------------------------------------------------------------------------
// p7pu_ctrl
// message sequencer: byte intake, pad burst, pad check and drain
// ---------------------------------------------------------------------------
module p7pu_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              is_last_i,
  input  logic              cfg_valid_i,
  output logic              in_stall_o,
  output logic              cfg_ready_o,
  input  p7pu_pkg::dp_sts_t sts_i,
  output p7pu_pkg::dp_cmd_t cmd_o
);
  import p7pu_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD_FILL,
    ST_EVICT,
    ST_CHK_START,
    ST_CHK_RD,
    ST_CHK_CMP,
    ST_FIN,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_ERR
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign take        = (state_q == ST_IDLE) && sts_i.slot_free && in_valid_i;
  assign in_stall_o  = !((state_q == ST_IDLE) && sts_i.slot_free);
  assign cfg_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.src    = SRC_IN;
    cmd_o.cfg_we = cfg_valid_i && (state_q == ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_head = 1'b1;
        if (take) begin
          cmd_o.take = 1'b1;
          if (!sts_i.unpad_mode) begin
            cmd_o.emit = 1'b1;
            cmd_o.src  = SRC_IN;
            if (is_last_i) begin
              state_d = ST_PAD_FILL;
            end
          end else if (sts_i.full) begin
            state_d = ST_EVICT;
          end else if (is_last_i) begin
            state_d = ST_CHK_START;
          end
        end
      end
      ST_PAD_FILL: begin
        if (sts_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.src       = SRC_PAD;
          cmd_o.emit_last = sts_i.cnt_one;
          cmd_o.pad_step  = 1'b1;
          if (sts_i.cnt_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EVICT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_RAM;
          state_d    = sts_i.last ? ST_CHK_START : ST_IDLE;
        end
      end
      ST_CHK_START: begin
        if (sts_i.pad_ok) begin
          cmd_o.chk_start = 1'b1;
          state_d         = ST_CHK_RD;
        end else begin
          state_d = ST_ERR;
        end
      end
      ST_CHK_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_CHK_CMP;
      end
      ST_CHK_CMP: begin
        if (!sts_i.byte_match) begin
          state_d = ST_ERR;
        end else if (sts_i.cnt_one) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.ptr_step = 1'b1;
          state_d        = ST_CHK_RD;
        end
      end
      ST_FIN: begin
        if (!sts_i.keep_zero) begin
          cmd_o.emit_start = 1'b1;
          state_d          = ST_EMIT_RD;
        end else if (sts_i.slot_free) begin
          // pad covered the whole window: status only
          cmd_o.emit      = 1'b1;
          cmd_o.src       = SRC_STATUS;
          cmd_o.emit_last = 1'b1;
          cmd_o.clear_msg = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.src       = SRC_RAM;
          cmd_o.emit_last = sts_i.cnt_one;
          if (sts_i.cnt_one) begin
            cmd_o.clear_msg = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.ptr_step = 1'b1;
            state_d        = ST_EMIT_RD;
          end
        end
      end
      ST_ERR: begin
        if (sts_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.src       = SRC_STATUS;
          cmd_o.emit_last = 1'b1;
          cmd_o.emit_err  = 1'b1;
          cmd_o.clear_msg = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hdl/pkcs7_pad_unpad_stream_unit.sv]
// ---------------------------------------------------------------------------
// pkcs7_pad_unpad_stream_unit
// pkcs#7 padder / unpadder for a byte stream with BLOCK_BYTES-byte blocks
// ---------------------------------------------------------------------------
// usage
//   input channel: one message byte per beat (data_byte_i, is_last_i), taken
//     when in_valid_i is high and in_stall_o is low
//   output channel: one result per beat (out_byte_o, byte_valid_o,
//     out_last_o, pad_error_o), taken when out_valid_o is high and
//     out_stall_i is low; results sit in an output register
//   config channel: unpad_mode_i written on cfg_valid_i and cfg_ready_o;
//     ready only while the sequencer is idle; a write drops the message state
//   pad mode: each byte appears the cycle after its beat, 1 byte per cycle;
//     after the last byte the pad burst follows at one byte per cycle, both unless stalled
//   unpad mode: while the hold window fills, input is taken back to back; once
//     full, each beat also reads the oldest byte, then an evict state gives
//     its output beat; the end check reads the window through the single ram
//     read port, first each pad byte (read, then compare), then each kept
//     byte (read, then output beat)
//   reset: asynchronous, active low; mode goes to pad, window and phase empty
//   a stalled receiver holds the output register; the block then stops
//     taking input and holds every state that emits until the beat is taken
// ---------------------------------------------------------------------------
module pkcs7_pad_unpad_stream_unit #(
  parameter int BLOCK_BYTES = p7pu_pkg::BLOCK_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // config
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       unpad_mode_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_last_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       out_last_o,
  output logic       pad_error_o
);
  import p7pu_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: decides when bytes enter, when results leave
  p7pu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .is_last_i   (is_last_i),
    .cfg_valid_i (cfg_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: hold window ram, counters and output register
  p7pu_datapath #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_data_i   (unpad_mode_i),
    .data_byte_i  (data_byte_i),
    .is_last_i    (is_last_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .out_last_o   (out_last_o),
    .pad_error_o  (pad_error_o)
  );

endmodule
